// ===== hdl/balt_pkg.sv =====
// Shared constants, types and the log2 table for the barometric altitude block.
// Used by balt_log2, balt_exp2 and barometric_altitude; depends on nothing else.
package balt_pkg;

  // Log table geometry
  localparam int LOG_TABLE_ENTRIES = 256;
  localparam int LOG_N   = $clog2(LOG_TABLE_ENTRIES);
  localparam int LT_W    = 17;            // table entry, holds 65536
  localparam int FR_W    = 30 - LOG_N;    // interpolation fraction bits
  localparam int EXP_Q   = 24 - LOG_N;    // mantissa quotient bits
  localparam int EXP_LAT = LOG_N + 1 + EXP_Q;

  // Field and datapath widths
  localparam int P_W     = 21;
  localparam int T_W     = 17;
  localparam int P0_W    = 17;
  localparam int L_W     = 18;
  localparam int ALT_W   = 27;
  localparam int MSB_W   = $clog2(P_W);
  localparam int LG_W    = 21;            // log2 result, Q16
  localparam int TC_W    = 17;            // absolute temperature, 0.01 K
  localparam int F_W     = 16;            // exponent fraction
  localparam int MANT_W  = 25;            // 2^f mantissa, Q24
  localparam int LMAG_W  = 18;

  // Scale constants
  localparam logic [20:0]        K_ISO         = 21'd1329702;
  localparam logic [16:0]        K_EXP         = 17'd125721;
  localparam logic [19:0]        SCALE_1E6     = 20'd1000000;
  localparam logic [17:0]        KELVIN_OFFSET = 18'd27315;
  localparam logic [ALT_W-1:0]   ALT_LIMIT     = 27'd50000000;
  localparam logic [MANT_W-1:0]  MANT_ONE      = 25'h1000000;
  localparam logic [P0_W-1:0]    P0_RESET      = 17'd101325;
  localparam logic [L_W-1:0]     LAPSE_RESET   = 18'd6500;

  // Configuration register indexes
  typedef enum logic {
    CFG_REF_PRESSURE = 1'b0,
    CFG_LAPSE_RATE   = 1'b1
  } cfg_idx_t;

  typedef logic [LT_W-1:0] log_tab_t [0:LOG_TABLE_ENTRIES];

  // log2(1+k/N) in Q16 by repeated squaring, last entry exactly 1.0
  function automatic log_tab_t build_log_tab();
    log_tab_t    tab;
    logic [63:0] x;
    logic [31:0] r;
    for (int k = 0; k <= LOG_TABLE_ENTRIES; k++) begin
      if (k == LOG_TABLE_ENTRIES) begin
        tab[k] = LT_W'(65536);
      end else begin
        x = ((64'(LOG_TABLE_ENTRIES) + 64'(k)) << 30) / LOG_TABLE_ENTRIES;
        r = '0;
        for (int j = 0; j < 17; j++) begin
          x = (x * x) >> 30;
          r = r << 1;
          if (x >= (64'd1 << 31)) begin
            r = r | 32'd1;
            x = x >> 1;
          end
        end
        tab[k] = LT_W'((r + 32'd1) >> 1);
      end
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

// ===== hdl/balt_log2.sv =====
// Two-stage log2 unit: normalize, then table lookup with linear interpolation.
// Result is Q16. Depends on balt_pkg.
module balt_log2 (
  input  logic                       clk,
  input  logic                       en,
  input  logic [balt_pkg::P_W-1:0]   v,
  output logic [balt_pkg::LG_W-1:0]  l_q16
);
  import balt_pkg::*;

  localparam int PR_W = LT_W + FR_W;
  localparam logic [PR_W-1:0] RND = PR_W'(1) << (FR_W - 1);

  logic [MSB_W-1:0] msb;
  logic [P_W-1:0]   norm;
  logic [29:0]      frac;
  logic [MSB_W-1:0] msb_r;
  logic [LOG_N-1:0] idx_r;
  logic [FR_W-1:0]  fr_r;
  logic [LT_W-1:0]  t0, t1, d, interp;
  logic [PR_W-1:0]  prod;
  logic [LG_W-1:0]  res_nxt, res_r;

  // Find the leading one and normalize to a Q30 fraction
  always_comb begin
    msb = '0;
    for (int b = 1; b < P_W; b++) begin
      if (v[b]) begin
        msb = MSB_W'(b);
      end
    end
    norm = v << (MSB_W'(P_W - 1) - msb);
    frac = 30'(norm[P_W-2:0]) << (30 - (P_W - 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      msb_r <= msb;
      idx_r <= frac[29 -: LOG_N];
      fr_r  <= frac[FR_W-1:0];
    end
  end

  // Interpolate between neighboring table entries
  always_comb begin
    t0      = LOG_TAB[idx_r];
    t1      = LOG_TAB[(LOG_N+1)'(idx_r) + 1'b1];
    d       = t1 - t0;
    prod    = PR_W'(d) * PR_W'(fr_r);
    interp  = LT_W'((prod + RND) >> FR_W);
    res_nxt = LG_W'({msb_r, 16'b0}) + LG_W'(t0) + LG_W'(interp);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign l_q16 = res_r;

endmodule

// ===== hdl/balt_exp2.sv =====
// Pipelined 2^(f/65536) in Q24: inverse table search, one step per stage,
// then a bit-per-stage divide for the interpolated fraction. Depends on balt_pkg.
module balt_exp2 (
  input  logic                         clk,
  input  logic                         en,
  input  logic [balt_pkg::F_W-1:0]     f,
  output logic [balt_pkg::MANT_W-1:0]  mant
);
  import balt_pkg::*;

  // Search stages
  logic [LOG_N-1:0] lo_r   [0:LOG_N-1];
  logic [F_W-1:0]   fs_r   [0:LOG_N-1];
  logic [LOG_N-1:0] lo_in  [0:LOG_N-1];
  logic [F_W-1:0]   f_in   [0:LOG_N-1];
  logic [LOG_N-1:0] lo_nxt [0:LOG_N-1];

  // Prep stage
  logic [LOG_N-1:0] lo_l;
  logic [LT_W-1:0]  ta, tb, den_nxt, rem_nxt;
  logic [LOG_N-1:0] pl_r;
  logic [LT_W-1:0]  pd_r, pr_r;

  // Divide stages
  logic [LT_W-1:0]  dr_r   [0:EXP_Q-1];
  logic [LT_W-1:0]  dd_r   [0:EXP_Q-1];
  logic [LOG_N-1:0] dl_r   [0:EXP_Q-1];
  logic [EXP_Q-1:0] dq_r   [0:EXP_Q-1];
  logic [LT_W-1:0]  r_in   [0:EXP_Q-1];
  logic [LT_W-1:0]  d_in   [0:EXP_Q-1];
  logic [LOG_N-1:0] l_in   [0:EXP_Q-1];
  logic [EXP_Q-1:0] q_in   [0:EXP_Q-1];
  logic [LT_W-1:0]  r_nxt  [0:EXP_Q-1];
  logic [EXP_Q-1:0] q_nxt  [0:EXP_Q-1];

  // Narrow the table interval by one bit per stage
  always_comb begin
    logic [LOG_N-1:0] mid;
    lo_in[0] = '0;
    f_in[0]  = f;
    for (int k = 1; k < LOG_N; k++) begin
      lo_in[k] = lo_r[k-1];
      f_in[k]  = fs_r[k-1];
    end
    for (int k = 0; k < LOG_N; k++) begin
      mid       = lo_in[k] | (LOG_N'(1) << (LOG_N - 1 - k));
      lo_nxt[k] = (LOG_TAB[mid] <= LT_W'(f_in[k])) ? mid : lo_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LOG_N; k++) begin
        lo_r[k] <= lo_nxt[k];
        fs_r[k] <= f_in[k];
      end
    end
  end

  // Interval width and offset into it
  always_comb begin
    lo_l    = lo_r[LOG_N-1];
    ta      = LOG_TAB[lo_l];
    tb      = LOG_TAB[(LOG_N+1)'(lo_l) + 1'b1];
    den_nxt = tb - ta;
    if (den_nxt == '0) begin
      den_nxt = LT_W'(1);
    end
    rem_nxt = LT_W'(fs_r[LOG_N-1]) - ta;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= lo_l;
      pd_r <= den_nxt;
      pr_r <= rem_nxt;
    end
  end

  // Restoring divide, one quotient bit per stage
  always_comb begin
    logic [LT_W:0] t;
    r_in[0] = pr_r;
    d_in[0] = pd_r;
    l_in[0] = pl_r;
    q_in[0] = '0;
    for (int k = 1; k < EXP_Q; k++) begin
      r_in[k] = dr_r[k-1];
      d_in[k] = dd_r[k-1];
      l_in[k] = dl_r[k-1];
      q_in[k] = dq_r[k-1];
    end
    for (int k = 0; k < EXP_Q; k++) begin
      t = {r_in[k], 1'b0};
      if (t >= (LT_W+1)'(d_in[k])) begin
        r_nxt[k] = LT_W'(t - (LT_W+1)'(d_in[k]));
        q_nxt[k] = {q_in[k][EXP_Q-2:0], 1'b1};
      end else begin
        r_nxt[k] = t[LT_W-1:0];
        q_nxt[k] = {q_in[k][EXP_Q-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < EXP_Q; k++) begin
        dr_r[k] <= r_nxt[k];
        dd_r[k] <= d_in[k];
        dl_r[k] <= l_in[k];
        dq_r[k] <= q_nxt[k];
      end
    end
  end

  assign mant = MANT_ONE + (MANT_W'(dl_r[EXP_Q-1]) << EXP_Q) + MANT_W'(dq_r[EXP_Q-1]);

endmodule

// ===== hdl/barometric_altitude.sv =====
// Top level of the barometric altitude block: config registers and the main
// pipeline. Depends on balt_pkg, balt_log2 and balt_exp2.
//
// Usage:
//   Input channel in_valid/in_stall carries one pressure (1/16 Pa) and one
//   temperature (0.01 degC) per item. Output channel out_valid/out_stall
//   carries altitude in cm with valid_res and saturated flags, one per item.
//   cfg_we/cfg_index/cfg_data write the reference pressure or the lapse rate;
//   write them only while no item is in flight.
// Timing:
//   The pipeline length from acceptance to out_valid is set by the 25-stage
//   exp2 unit (table search plus divide) and the 26-stage quotient for the
//   polytropic scaling by 1/L.
//   One item is accepted every cycle while the output is taken.
// Reset:
//   rst_n clears all valid bits and loads the reference pressure (101325 Pa)
//   and the lapse rate (6500 uK/m). The block accepts items right away.
// Stall:
//   When out_stall holds a waiting result, every stage holds and in_stall
//   rises in the same cycle; nothing is dropped or repeated.
module barometric_altitude (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [balt_pkg::P_W-1:0]            in_pressure,
  input  logic signed [balt_pkg::T_W-1:0]     in_temperature,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [balt_pkg::ALT_W-1:0]   out_altitude,
  output logic                                out_valid_res,
  output logic                                out_saturated,
  input  logic                                cfg_we,
  input  balt_pkg::cfg_idx_t                  cfg_index,
  input  logic [balt_pkg::L_W-1:0]            cfg_data
);
  import balt_pkg::*;

  localparam int R_W    = 29;
  localparam int A_W    = 38;
  localparam int A_LO   = 19;
  localparam int PP_W   = 40;
  localparam int SUM_W  = 62;
  localparam int AX_W   = R_W - 16;
  localparam int SH_W   = AX_W + 1;
  localparam int Q_W    = 48;
  localparam int M_W    = 37;
  localparam int M_LO   = 19;
  localparam int Q_LO   = 24;
  localparam int PR_W   = 43;
  localparam int NUM_W  = 85;
  localparam int X_W    = 62;
  localparam int DIV_Q  = 26;
  localparam int HI_W   = X_W - DIV_Q;
  localparam int NST    = 9 + EXP_LAT + DIV_Q;

  typedef struct packed {
    logic             ok;
    logic [TC_W-1:0]  tc;
    logic             pb;
    logic [AX_W-1:0]  a;
    logic             bz;
    logic [R_W-1:0]   r;
    logic             lgneg;
  } side_t;

  typedef struct packed {
    logic             ok;
    logic             satd;
    logic             neg;
    logic             ovf;
    logic [R_W-1:0]   r;
  } fin_t;

  // Configuration
  logic [P0_W-1:0]    p0_r;
  logic [L_W-1:0]     lr_r;
  logic [P0_W-1:0]    p0_eff;
  logic [P_W-1:0]     v0;
  logic               l_neg, iso;
  logic [LMAG_W-1:0]  lmag;

  // Flow control
  logic               adv;
  logic [NST-1:0]     vld_r;
  logic               out_valid_r;

  // Front stages
  logic [17:0]        tc1_nxt;
  logic               ok1_nxt;
  logic [TC_W-1:0]    tc1_r, tc2_r, tc3_r, tc4_r, tc5_r;
  logic               ok1_r, ok2_r, ok3_r, ok4_r, ok5_r;
  logic [LG_W-1:0]    lp, l0;
  logic [LG_W:0]      lg_s;
  logic [LG_W-1:0]    lgmag3_nxt, lgmag3_r;
  logic               lgneg3_r, lgneg4_r, lgneg5_r;
  logic [A_W-1:0]     a3_nxt, a3_r;
  logic [PP_W-1:0]    pplo4_r, pphi4_r;
  logic [SUM_W-1:0]   sum5;
  logic [R_W-1:0]     r5_r;

  // Exponent side path
  logic [F_W-1:0]     f6;
  side_t              sb_nxt;
  side_t              sb_r [0:EXP_LAT-1];
  logic [MANT_W-1:0]  mant;

  // Scaling stages
  side_t              sx;
  logic [Q_W-1:0]     shl, qpb, qnp, qe_nxt, qe_r;
  logic [SH_W-1:0]    sh;
  logic [MANT_W-1:0]  base, p24;
  logic [M_W-1:0]     me_nxt, me_r;
  fin_t               fe_nxt, fe_r, f1_r, f2_r, f3_nxt, f3_r;
  logic [PR_W-1:0]    pll_r, plh_r, phl_r, phh_r;
  logic [NUM_W-1:0]   num_r, numr;
  logic [X_W-1:0]     xs;
  logic [HI_W-1:0]    hi;
  logic [LMAG_W-1:0]  rem0_r;
  logic [DIV_Q-1:0]   xl_r;

  // Divide stages
  logic [LMAG_W-1:0]  dr_r  [0:DIV_Q-1];
  logic [DIV_Q-1:0]   dx_r  [0:DIV_Q-1];
  logic [DIV_Q-1:0]   dq_r  [0:DIV_Q-1];
  fin_t               df_r  [0:DIV_Q-1];
  logic [LMAG_W-1:0]  rin   [0:DIV_Q-1];
  logic [DIV_Q-1:0]   xin   [0:DIV_Q-1];
  logic [DIV_Q-1:0]   qin   [0:DIV_Q-1];
  logic [LMAG_W-1:0]  r_nxt [0:DIV_Q-1];
  logic [DIV_Q-1:0]   q_nxt [0:DIV_Q-1];

  // Output
  fin_t               fl;
  logic               over;
  logic [R_W-1:0]     val;
  logic [ALT_W-1:0]   mag27;
  logic [ALT_W-1:0]   alt_nxt, alt_r;
  logic               vres_nxt, vres_r, sat_nxt, sat_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r <= P0_RESET;
      lr_r <= LAPSE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REF_PRESSURE: p0_r <= cfg_data[P0_W-1:0];
        CFG_LAPSE_RATE:   lr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    p0_eff = (p0_r == '0) ? P0_W'(1) : p0_r;
    v0     = {p0_eff, 4'b0};
    l_neg  = lr_r[L_W-1];
    iso    = (lr_r == '0);
    lmag   = l_neg ? LMAG_W'(-lr_r) : LMAG_W'(lr_r);
  end

  // Advance the whole pipe unless a finished result waits
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NST-2:0], in_valid};
      out_valid_r <= vld_r[NST-1];
    end
  end

  // Stage 1: absolute temperature and sample check
  always_comb begin
    tc1_nxt = {in_temperature[T_W-1], in_temperature} + KELVIN_OFFSET;
    ok1_nxt = (in_pressure != '0) && !tc1_nxt[17] && (tc1_nxt != '0);
  end

  balt_log2 u_log_p (
    .clk   (clk),
    .en    (adv),
    .v     (in_pressure),
    .l_q16 (lp)
  );

  balt_log2 u_log_0 (
    .clk   (clk),
    .en    (adv),
    .v     (v0),
    .l_q16 (l0)
  );

  // Stage 3: log ratio and first scale product
  always_comb begin
    lg_s       = {1'b0, l0} - {1'b0, lp};
    lgmag3_nxt = lg_s[LG_W] ? LG_W'(-lg_s) : lg_s[LG_W-1:0];
    a3_nxt     = iso ? A_W'(tc2_r) * A_W'(K_ISO) : A_W'(lmag) * A_W'(K_EXP);
  end

  // Stage 5: combine partial products and round the Q32 scale away
  assign sum5 = (SUM_W'(pphi4_r) << A_LO) + SUM_W'(pplo4_r) + (SUM_W'(1) << 31);

  always_ff @(posedge clk) begin
    if (adv) begin
      tc1_r    <= tc1_nxt[TC_W-1:0];
      ok1_r    <= ok1_nxt;
      tc2_r    <= tc1_r;
      ok2_r    <= ok1_r;
      tc3_r    <= tc2_r;
      ok3_r    <= ok2_r;
      lgmag3_r <= lgmag3_nxt;
      lgneg3_r <= lg_s[LG_W];
      a3_r     <= a3_nxt;
      pplo4_r  <= PP_W'(a3_r[A_LO-1:0]) * PP_W'(lgmag3_r);
      pphi4_r  <= PP_W'(a3_r[A_W-1:A_LO]) * PP_W'(lgmag3_r);
      tc4_r    <= tc3_r;
      ok4_r    <= ok3_r;
      lgneg4_r <= lgneg3_r;
      r5_r     <= sum5[32 +: R_W];
      tc5_r    <= tc4_r;
      ok5_r    <= ok4_r;
      lgneg5_r <= lgneg4_r;
    end
  end

  // Split the exponent and pick the table argument
  always_comb begin
    sb_nxt.ok    = ok5_r;
    sb_nxt.tc    = tc5_r;
    sb_nxt.pb    = (l_neg != lgneg5_r) && (r5_r != '0);
    sb_nxt.a     = r5_r[R_W-1:16];
    sb_nxt.bz    = (r5_r[15:0] == '0);
    sb_nxt.r     = r5_r;
    sb_nxt.lgneg = lgneg5_r;
    f6           = sb_nxt.pb ? r5_r[15:0] : F_W'(16'd0 - r5_r[15:0]);
  end

  balt_exp2 u_exp (
    .clk  (clk),
    .en   (adv),
    .f    (f6),
    .mant (mant)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= sb_nxt;
      for (int k = 1; k < EXP_LAT; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  // Turn the mantissa into the power difference term
  always_comb begin
    sx          = sb_r[EXP_LAT-1];
    shl         = Q_W'(mant) << sx.a[4:0];
    qpb         = shl - Q_W'(MANT_ONE);
    sh          = sx.bz ? SH_W'(sx.a) : SH_W'(sx.a) + 1'b1;
    base        = sx.bz ? MANT_ONE : mant;
    p24         = (sh >= SH_W'(40)) ? '0 : base >> sh[5:0];
    qnp         = Q_W'(MANT_ONE) - Q_W'(p24);
    qe_nxt      = sx.pb ? qpb : qnp;
    me_nxt      = M_W'(sx.tc) * M_W'(SCALE_1E6);
    fe_nxt.ok   = sx.ok;
    fe_nxt.satd = sx.pb && (sx.a >= AX_W'(24));
    fe_nxt.neg  = iso ? sx.lgneg : (l_neg != sx.pb);
    fe_nxt.ovf  = 1'b0;
    fe_nxt.r    = sx.r;
  end

  // Rounded numerator for the divide by L * 2^24
  always_comb begin
    numr       = num_r + (NUM_W'(lmag) << 23);
    xs         = X_W'(numr >> 24);
    hi         = xs[X_W-1:DIV_Q];
    f3_nxt     = f2_r;
    f3_nxt.ovf = (hi >= HI_W'(lmag));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qe_r   <= qe_nxt;
      me_r   <= me_nxt;
      fe_r   <= fe_nxt;
      pll_r  <= PR_W'(me_r[M_LO-1:0]) * PR_W'(qe_r[Q_LO-1:0]);
      plh_r  <= PR_W'(me_r[M_LO-1:0]) * PR_W'(qe_r[Q_W-1:Q_LO]);
      phl_r  <= PR_W'(me_r[M_W-1:M_LO]) * PR_W'(qe_r[Q_LO-1:0]);
      phh_r  <= PR_W'(me_r[M_W-1:M_LO]) * PR_W'(qe_r[Q_W-1:Q_LO]);
      f1_r   <= fe_r;
      num_r  <= NUM_W'(pll_r) + (NUM_W'(plh_r) << Q_LO) + (NUM_W'(phl_r) << M_LO)
                + (NUM_W'(phh_r) << (M_LO + Q_LO));
      f2_r   <= f1_r;
      rem0_r <= hi[LMAG_W-1:0];
      xl_r   <= xs[DIV_Q-1:0];
      f3_r   <= f3_nxt;
    end
  end

  // Restoring divide by |L|, one quotient bit per stage
  always_comb begin
    logic [LMAG_W:0] t;
    rin[0] = rem0_r;
    xin[0] = xl_r;
    qin[0] = '0;
    for (int k = 1; k < DIV_Q; k++) begin
      rin[k] = dr_r[k-1];
      xin[k] = dx_r[k-1];
      qin[k] = dq_r[k-1];
    end
    for (int k = 0; k < DIV_Q; k++) begin
      t = {rin[k], xin[k][DIV_Q-1]};
      if (t >= (LMAG_W+1)'(lmag)) begin
        r_nxt[k] = LMAG_W'(t - (LMAG_W+1)'(lmag));
        q_nxt[k] = {qin[k][DIV_Q-2:0], 1'b1};
      end else begin
        r_nxt[k] = t[LMAG_W-1:0];
        q_nxt[k] = {qin[k][DIV_Q-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      df_r[0] <= f3_r;
      for (int k = 1; k < DIV_Q; k++) begin
        df_r[k] <= df_r[k-1];
      end
      for (int k = 0; k < DIV_Q; k++) begin
        dr_r[k] <= r_nxt[k];
        dx_r[k] <= xin[k] << 1;
        dq_r[k] <= q_nxt[k];
      end
    end
  end

  // Clamp, apply sign, zero invalid samples
  always_comb begin
    fl = df_r[DIV_Q-1];
    if (iso) begin
      val  = fl.r;
      over = (fl.r > R_W'(ALT_LIMIT));
    end else begin
      val  = R_W'(dq_r[DIV_Q-1]);
      over = fl.satd || fl.ovf || (R_W'(dq_r[DIV_Q-1]) > R_W'(ALT_LIMIT));
    end
    mag27    = over ? ALT_LIMIT : val[ALT_W-1:0];
    alt_nxt  = fl.neg ? ALT_W'(-mag27) : mag27;
    vres_nxt = fl.ok;
    sat_nxt  = fl.ok && over;
    if (!fl.ok) begin
      alt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      alt_r  <= alt_nxt;
      vres_r <= vres_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_altitude  = alt_r;
  assign out_valid_res = vres_r;
  assign out_saturated = sat_r;

endmodule
